### rtl/backslash_escape_codec_assert.svh
// assertion macros used by the checker file
`ifndef BACKSLASH_ESCAPE_CODEC_ASSERT_SVH
`define BACKSLASH_ESCAPE_CODEC_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bec check failed");

// next-cycle implication, disabled during reset
`define BEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bec check failed");

`endif

### rtl/bec_pkg.sv
`default_nettype none
package bec_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 2'd1;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

  // direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DEL       = 8'h7F;

  typedef struct packed {
    logic        direction;
    logic [15:0] max_length;
  } cfg_t;

  // one classified request: up to four bytes, first byte in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_bytes;
    logic            line_end;
    logic            err;
  } job_t;

  function automatic logic is_control(input logic [7:0] b);
    return (b < CH_SPACE) || (b == CH_DEL);
  endfunction

  // upper-case hex digit for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

  // {ok, nibble}; ok low when not 0-9 or A-F
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

endpackage
`default_nettype wire

### rtl/bec_fifo.sv
`default_nettype none
module bec_fifo
  import bec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      push_ready,
  input  wire logic pop,
  output job_t      head,
  output logic      head_valid
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  logic do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/bec_front.sv
`default_nettype none
module bec_front
  import bec_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_line_end,
  output logic            job_push,
  output job_t            job,
  input  wire logic       job_ready
);

  localparam int CW = (COUNT_BITS + 1 > 17) ? COUNT_BITS + 1 : 17;

  typedef enum logic [1:0] {PH_PLAIN, PH_ESC, PH_HEX_HI, PH_HEX_LO} phase_t;

  phase_t                phase_r, phase_nxt;
  logic [3:0]            high_nib_r, high_nib_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  error_r, error_nxt;

  logic accept;

  assign in_ready = job_ready;
  assign accept   = in_valid && job_ready;
  assign job_push = accept;

  always_comb begin
    logic [2:0]      n;
    logic [3:0][7:0] b;
    logic [4:0]      hv;
    logic [7:0]      dec;
    logic [CW-1:0]   next;
    logic            over;
    n            = 3'd0;
    b            = '0;
    hv           = hex_val(in_byte);
    dec          = {high_nib_r, hv[3:0]};
    next         = '0;
    over         = 1'b0;
    phase_nxt    = phase_r;
    high_nib_nxt = high_nib_r;
    count_nxt    = count_r;
    error_nxt    = error_r;
    if (!error_r) begin
      if (cfg.direction == DIR_ENCODE) begin
        if (in_byte == CH_BACKSLASH) begin
          b = {16'h0, CH_BACKSLASH, CH_BACKSLASH}; n = 3'd2;
        end else if (in_byte == CH_NEWLINE) begin
          b = {16'h0, CH_LOWER_N, CH_BACKSLASH}; n = 3'd2;
        end else if (in_byte == CH_CR) begin
          b = {16'h0, CH_LOWER_R, CH_BACKSLASH}; n = 3'd2;
        end else if (in_byte == CH_TAB) begin
          b = {16'h0, CH_LOWER_T, CH_BACKSLASH}; n = 3'd2;
        end else if (is_control(in_byte)) begin
          b = {hex_char(in_byte[3:0]), hex_char(in_byte[7:4]), CH_LOWER_X, CH_BACKSLASH};
          n = 3'd4;
        end else begin
          b = {24'h0, in_byte}; n = 3'd1;
        end
      end else begin
        case (phase_r)
          PH_PLAIN: begin
            if (in_byte == CH_BACKSLASH) phase_nxt = PH_ESC;
            else if (is_control(in_byte)) error_nxt = 1'b1;
            else begin
              b = {24'h0, in_byte}; n = 3'd1;
            end
          end
          PH_ESC: begin
            phase_nxt = PH_PLAIN;
            if (in_byte == CH_BACKSLASH) begin
              b = {24'h0, CH_BACKSLASH}; n = 3'd1;
            end else if (in_byte == CH_LOWER_N) begin
              b = {24'h0, CH_NEWLINE}; n = 3'd1;
            end else if (in_byte == CH_LOWER_R) begin
              b = {24'h0, CH_CR}; n = 3'd1;
            end else if (in_byte == CH_LOWER_T) begin
              b = {24'h0, CH_TAB}; n = 3'd1;
            end else if (in_byte == CH_LOWER_X) phase_nxt = PH_HEX_HI;
            else error_nxt = 1'b1;
          end
          PH_HEX_HI: begin
            if (!hv[4]) begin
              error_nxt = 1'b1;
              phase_nxt = PH_PLAIN;
            end else begin
              high_nib_nxt = hv[3:0];
              phase_nxt    = PH_HEX_LO;
            end
          end
          PH_HEX_LO: begin
            phase_nxt = PH_PLAIN;
            if (!hv[4] || dec == 8'h00) error_nxt = 1'b1;
            else begin
              b = {24'h0, dec}; n = 3'd1;
            end
          end
          default: phase_nxt = PH_PLAIN;
        endcase
      end
      // length limit covers the whole escape
      next = CW'(count_r) + CW'(n);
      over = (next > CW'(cfg.max_length)) || next[COUNT_BITS];
      if (n != 3'd0) begin
        if (over) begin
          error_nxt = 1'b1;
          n         = 3'd0;
        end else begin
          count_nxt = next[COUNT_BITS-1:0];
        end
      end
      // cut-off escape or empty line
      if (in_line_end && !error_nxt && cfg.direction == DIR_DECODE &&
          (phase_nxt != PH_PLAIN || count_nxt == '0)) begin
        error_nxt = 1'b1;
      end
    end
    job.bytes     = b;
    job.has_bytes = (n != 3'd0);
    job.last_idx  = (n != 3'd0) ? 2'(n - 3'd1) : 2'd0;
    job.line_end  = in_line_end;
    job.err       = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PLAIN;
      high_nib_r <= 4'h0;
      count_r    <= '0;
      error_r    <= 1'b0;
    end else if (accept) begin
      if (in_line_end) begin
        phase_r    <= PH_PLAIN;
        high_nib_r <= 4'h0;
        count_r    <= '0;
        error_r    <= 1'b0;
      end else begin
        phase_r    <= phase_nxt;
        high_nib_r <= high_nib_nxt;
        count_r    <= count_nxt;
        error_r    <= error_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/bec_back.sv
`default_nettype none
module bec_back
  import bec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t head,
  input  wire logic head_valid,
  output logic      pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_line_done,
  output logic       out_line_error
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, run_last_r, done_r, err_r;

  logic load, last;

  assign load = head_valid && (!valid_r || out_ready);
  assign last = (idx_r == head.last_idx);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= head.has_bytes ? head.bytes[idx_r] : 8'h00;
      bvalid_r   <= head.has_bytes;
      run_last_r <= last;
      done_r     <= last && head.line_end;
      err_r      <= head.err;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_run_last   = run_last_r;
  assign out_line_done  = done_r;
  assign out_line_error = err_r;

endmodule
`default_nettype wire

### rtl/backslash_escape_codec.sv
`default_nettype none
// backslash escape codec: a line-oriented byte stream, one byte per input request with
// in_line_end on the last byte of a line. direction 0 encodes (backslash, newline, cr and
// tab become two-byte escapes, other control bytes and 0x7f become \xHH with upper-case hex),
// direction 1 decodes; out_line_error, sticky to line end, rises on malformed decode input or
// when a line's output would pass max_length bytes; the rest of an errored line is dropped.
// every input request yields one to four result requests, one per produced byte, or a single
// result with out_byte_valid low; out_run_last closes each input's results and out_line_done
// closes the line. rate: the output register sends one result per cycle while out_ready is
// high, so plain bytes and all decode traffic give one result and encode escapes two or four;
// a two-entry queue between classifier and output stage keeps one byte per cycle streaming
// with no bubbles while out_ready holds. the first result of an input passes through the
// queue and then the output register before it shows on the outputs. configuration
// (index 0 direction, index 1 max_length) is to be written by the user only while idle (not
// enforced by the block); cfg_ready is always high and writes to other indexes are ignored
module backslash_escape_codec
  import bec_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_line_end,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_run_last,
  output logic                        out_line_done,
  output logic                        out_line_error
);

  // configuration registers
  cfg_t cfg_r;

  // front to queue
  logic job_push, job_ready;
  job_t job;

  // queue to back
  job_t head;
  logic head_valid, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction  <= DIR_ENCODE;
      cfg_r.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIRECTION:  cfg_r.direction  <= cfg_data[0];
        REG_MAX_LENGTH: cfg_r.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // classifier: escape state, length count, error tracking
  bec_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_line_end (in_line_end),
    .job_push    (job_push),
    .job         (job),
    .job_ready   (job_ready)
  );

  // short queue so the classifier keeps going while results wait
  bec_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  (job),
    .push_ready (job_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // result stage: walks each request's bytes into the output register
  bec_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_line_done  (out_line_done),
    .out_line_error (out_line_error)
  );

endmodule
`default_nettype wire

### rtl/bec_checker.sv
`default_nettype none
`include "backslash_escape_codec_assert.svh"
module bec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_run_last,
  input wire logic       out_line_done,
  input wire logic       out_line_error
);

  // a result with no byte carries zero and closes its input
  `BEC_ASSERT_NOW(a_empty_zero, out_valid && !out_byte_valid, out_byte == 8'h00 && out_run_last)
  // line end is always the last result of its input
  `BEC_ASSERT_NOW(a_done_last, out_valid && out_line_done, out_run_last)
  // a result flagged with the line error never carries a byte
  `BEC_ASSERT_NOW(a_err_nobyte, out_valid && out_line_error, !out_byte_valid)
  // stalled result holds
  `BEC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(out_run_last))

endmodule

bind backslash_escape_codec bec_checker u_bec_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_run_last   (out_run_last),
  .out_line_done  (out_line_done),
  .out_line_error (out_line_error)
);
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bec_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam longint COUNT_LIMIT = (64'd1 << COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASE_ITEMS = 60;
  localparam int IDLE_PCT = 38;
  localparam int PRINT_CAP = 30;

  // ascii used for hex digits
  localparam logic [7:0] DIGIT_0 = "0";
  localparam logic [7:0] DIGIT_9 = "9";
  localparam logic [7:0] DIGIT_A = "A";
  localparam logic [7:0] DIGIT_F = "F";
  localparam logic [7:0] LOWER_A = "a";
  localparam logic [7:0] LOWER_F = "f";

  // decode progress inside an escape sequence
  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_BACKSLASH,
    PH_HEX_HIGH,
    PH_HEX_LOW
  } esc_state_e;

  // one input request waiting to go out
  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       hold;   // wait until all results are back before sending
  } byte_req_t;

  // one predicted result request
  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       run_last;
    logic       line_done;
    logic       line_error;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_byte = '0;
  logic                   in_line_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_byte_valid;
  logic                   out_run_last;
  logic                   out_line_done;
  logic                   out_line_error;

  backslash_escape_codec #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_line_end    (in_line_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_line_done  (out_line_done),
    .out_line_error (out_line_error)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_req_t     line_bytes_q[$];   // requests not yet offered to the block
  codec_result_t codec_out_q[$];    // predicted results, oldest first

  // shadow of the configuration registers
  logic        cfg_dir = DIR_ENCODE;
  logic [15:0] cfg_max = MAX_LENGTH_RESET;

  // shadow of the line state
  esc_state_e  esc_state = PH_PLAIN;
  logic [3:0]  hex_high = '0;
  longint      line_count = 0;
  logic        line_err = 1'b0;

  bit calm = 1'b0;       // no idling on either side while set
  int mismatches = 0;
  int queued_items = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int error_lines = 0;
  int cfg_writes = 0;
  int phase = 0;

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t mismatch at result %0d: %s got %h want %h",
               $realtime, results_seen, what, got, want);
  endtask

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    return (n < 10) ? 8'(DIGIT_0 + n) : 8'(DIGIT_A + n - 10);
  endfunction

  // value of an upper-case hex digit, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= DIGIT_0 && b <= DIGIT_9) return int'(b - DIGIT_0);
    if (b >= DIGIT_A && b <= DIGIT_F) return int'(b - DIGIT_A) + 10;
    return -1;
  endfunction

  // works out the results of one accepted request and queues them
  task automatic escape_codec_step(input logic [7:0] b, input logic eol);
    logic [7:0]    emit [4];
    logic [7:0]    val;
    int            n, nib, k, i;
    longint        total;
    bit            pair;
    codec_result_t r;
    n = 0;
    pair = 1'b0;
    if (!line_err) begin
      if (cfg_dir == DIR_ENCODE) begin
        // encode keeps the escape state untouched
        emit[0] = CH_BACKSLASH;
        case (b)
          CH_BACKSLASH: begin pair = 1'b1; emit[1] = CH_BACKSLASH; end
          CH_NEWLINE:   begin pair = 1'b1; emit[1] = CH_LOWER_N; end
          CH_CR:        begin pair = 1'b1; emit[1] = CH_LOWER_R; end
          CH_TAB:       begin pair = 1'b1; emit[1] = CH_LOWER_T; end
          default:      pair = 1'b0;
        endcase
        if (pair) begin
          n = 2;
        end else if (b < CH_SPACE || b == CH_DEL) begin
          emit[1] = CH_LOWER_X;
          emit[2] = nib_char(b[7:4]);
          emit[3] = nib_char(b[3:0]);
          n = 4;
        end else begin
          emit[0] = b;
          n = 1;
        end
      end else begin
        case (esc_state)
          PH_PLAIN: begin
            if (b == CH_BACKSLASH) esc_state = PH_BACKSLASH;
            else if (b < CH_SPACE || b == CH_DEL) line_err = 1'b1;
            else begin emit[0] = b; n = 1; end
          end
          PH_BACKSLASH: begin
            esc_state = PH_PLAIN;
            case (b)
              CH_BACKSLASH: begin emit[0] = CH_BACKSLASH; n = 1; end
              CH_LOWER_N:   begin emit[0] = CH_NEWLINE; n = 1; end
              CH_LOWER_R:   begin emit[0] = CH_CR; n = 1; end
              CH_LOWER_T:   begin emit[0] = CH_TAB; n = 1; end
              CH_LOWER_X:   esc_state = PH_HEX_HIGH;
              default:      line_err = 1'b1;
            endcase
          end
          PH_HEX_HIGH: begin
            nib = hex_nibble(b);
            if (nib < 0) begin
              line_err = 1'b1;
              esc_state = PH_PLAIN;
            end else begin
              hex_high = 4'(nib);
              esc_state = PH_HEX_LOW;
            end
          end
          default: begin
            nib = hex_nibble(b);
            esc_state = PH_PLAIN;
            if (nib < 0) begin
              line_err = 1'b1;
            end else begin
              val = {hex_high, 4'(nib)};
              // a decoded zero byte is refused
              if (val == '0) line_err = 1'b1;
              else begin emit[0] = val; n = 1; end
            end
          end
        endcase
      end
      // an item that would pass the length limit emits nothing at all
      if (n > 0) begin
        total = line_count + n;
        if (total > longint'(cfg_max) || total > COUNT_LIMIT) begin
          line_err = 1'b1;
          n = 0;
        end else begin
          line_count = total;
        end
      end
      // decode: escape cut off at line end, or nothing produced
      if (eol && !line_err && cfg_dir == DIR_DECODE &&
          (esc_state != PH_PLAIN || line_count == 0))
        line_err = 1'b1;
    end
    k = (n > 0) ? n : 1;
    for (i = 0; i < k; i++) begin
      r.data       = (n > 0) ? emit[i] : 8'h00;
      r.data_ok    = (n > 0);
      r.run_last   = (i == k - 1);
      r.line_done  = (i == k - 1) && eol;
      r.line_error = line_err;
      codec_out_q.push_back(r);
    end
    if (eol) begin
      esc_state = PH_PLAIN;
      hex_high = '0;
      line_count = 0;
      line_err = 1'b0;
    end
  endtask

  // driver: offers queued requests, holds each one until it is taken
  always @(posedge clk) begin : request_driver
    byte_req_t head;
    logic      go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        items_accepted++;
        escape_codec_step(in_byte, in_line_end);
      end
      if (!in_valid || in_ready) begin
        go = 1'b0;
        if (line_bytes_q.size() != 0) begin
          head = line_bytes_q[0];
          // random gaps, and a pause for a drained pipe where asked
          go = (calm || $urandom_range(99) >= IDLE_PCT) &&
               (!head.hold || codec_out_q.size() == 0);
        end
        if (go) begin
          head = line_bytes_q.pop_front();
          in_byte     <= head.data;
          in_line_end <= head.eol;
        end
        in_valid <= go;
      end
    end
  end

  // monitor: checks every taken result against the oldest prediction
  always @(posedge clk) begin : result_monitor
    codec_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (codec_out_q.size() == 0) begin
          flag_mismatch("result with none expected, out_byte", out_byte, 8'h00);
        end else begin
          want = codec_out_q.pop_front();
          if (out_byte !== want.data)
            flag_mismatch("out_byte", out_byte, want.data);
          if (out_byte_valid !== want.data_ok)
            flag_mismatch("out_byte_valid", 8'(out_byte_valid), 8'(want.data_ok));
          if (out_run_last !== want.run_last)
            flag_mismatch("out_run_last", 8'(out_run_last), 8'(want.run_last));
          if (out_line_done !== want.line_done)
            flag_mismatch("out_line_done", 8'(out_line_done), 8'(want.line_done));
          if (out_line_error !== want.line_error)
            flag_mismatch("out_line_error", 8'(out_line_error), 8'(want.line_error));
          if (want.line_done && want.line_error) error_lines++;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_req(input logic [7:0] d, input logic eol, input logic hold);
    byte_req_t q;
    q.data = d;
    q.eol  = eol;
    q.hold = hold;
    line_bytes_q.push_back(q);
    queued_items++;
  endtask

  // queue a string, line end on its last char when finish is set
  task automatic push_text(input string s, input bit finish, input bit hold);
    int i;
    for (i = 0; i < s.len(); i++)
      push_req(s[i], finish && (i == s.len() - 1), hold && (i == 0));
  endtask

  task automatic push_seq(ref logic [7:0] seq[$], input bit finish);
    int i;
    bit hold;
    hold = ($urandom_range(99) < 4);
    for (i = 0; i < seq.size(); i++)
      push_req(seq[i], finish && (i == seq.size() - 1), hold && (i == 0));
  endtask

  // raw bytes for encode, biased toward the bytes that need escaping
  task automatic gen_raw_line(input bit finish);
    logic [7:0] seq[$];
    int len, i, pick;
    len = $urandom_range(1, 12);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        case ($urandom_range(3))
          0:       seq.push_back(CH_BACKSLASH);
          1:       seq.push_back(CH_NEWLINE);
          2:       seq.push_back(CH_CR);
          default: seq.push_back(CH_TAB);
        endcase
      end else if (pick < 60) begin
        seq.push_back(8'($urandom_range(255)));
      end else begin
        seq.push_back(8'($urandom_range(CH_SPACE, CH_DEL - 1)));
      end
    end
    push_seq(seq, finish);
  endtask

  // escaped text for decode: mostly well formed, some lines carry one defect
  task automatic gen_escaped_line(input bit finish);
    logic [7:0] seq[$];
    logic [7:0] v;
    int tokens, bad_at, t, pick;
    bit broken, cut;
    tokens = $urandom_range(1, 10);
    broken = ($urandom_range(99) < 22);
    bad_at = $urandom_range(0, tokens - 1);
    cut = 1'b0;
    for (t = 0; t < tokens && !cut; t++) begin
      if (broken && t == bad_at) begin
        case ($urandom_range(5))
          0: seq.push_back(8'($urandom_range(255)));
          1: begin
            seq.push_back(CH_BACKSLASH);
            seq.push_back(8'($urandom_range(255)));
          end
          2: begin
            // lower-case hex digit
            seq.push_back(CH_BACKSLASH);
            seq.push_back(CH_LOWER_X);
            seq.push_back(nib_char(4'($urandom_range(15))));
            seq.push_back(8'($urandom_range(LOWER_A, LOWER_F)));
          end
          3: begin
            // decodes to zero
            seq.push_back(CH_BACKSLASH);
            seq.push_back(CH_LOWER_X);
            seq.push_back(DIGIT_0);
            seq.push_back(DIGIT_0);
          end
          4: begin
            seq.push_back(CH_BACKSLASH);
            seq.push_back(CH_LOWER_X);
            seq.push_back(8'($urandom_range(255)));
            seq.push_back(8'($urandom_range(255)));
          end
          default: begin
            // escape left hanging at line end
            v = 8'($urandom_range(2));
            seq.push_back(CH_BACKSLASH);
            if (v != 0) seq.push_back(CH_LOWER_X);
            if (v == 2) seq.push_back(nib_char(4'($urandom_range(15))));
            cut = 1'b1;
          end
        endcase
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          do v = 8'($urandom_range(CH_SPACE, 8'hFF));
          while (v == CH_BACKSLASH || v == CH_DEL);
          seq.push_back(v);
        end else if (pick < 75) begin
          seq.push_back(CH_BACKSLASH);
          case ($urandom_range(3))
            0:       seq.push_back(CH_BACKSLASH);
            1:       seq.push_back(CH_LOWER_N);
            2:       seq.push_back(CH_LOWER_R);
            default: seq.push_back(CH_LOWER_T);
          endcase
        end else begin
          v = 8'($urandom_range(1, 255));
          seq.push_back(CH_BACKSLASH);
          seq.push_back(CH_LOWER_X);
          seq.push_back(nib_char(v[7:4]));
          seq.push_back(nib_char(v[3:0]));
        end
      end
    end
    push_seq(seq, finish);
  endtask

  // config write, caller sits on a rising edge
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_DIRECTION) cfg_dir = val[0];
    else if (idx == REG_MAX_LENGTH) cfg_max = val;
    cfg_writes++;
    @(posedge clk);
  endtask

  // all requests sent and every predicted result back
  task automatic wait_idle();
    while (line_bytes_q.size() != 0 || in_valid || codec_out_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    logic        dir;
    logic [15:0] maxl;
    int          random_start, phase_start;
    bit          open_line;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode with reset values: every escape kind, zero byte, boundaries
    push_req(CH_BACKSLASH, 1'b0, 1'b0);
    push_req(CH_NEWLINE, 1'b0, 1'b0);
    push_req(CH_CR, 1'b0, 1'b0);
    push_req(CH_TAB, 1'b0, 1'b0);
    push_req(8'h00, 1'b0, 1'b0);
    push_req(CH_DEL, 1'b0, 1'b0);
    push_req(CH_SPACE, 1'b0, 1'b0);
    push_req(8'hFF, 1'b1, 1'b0);
    wait_idle();

    // decode: good escapes, then one line per kind of defect
    write_reg(REG_DIRECTION, 16'(DIR_DECODE));
    push_text("\\n\\xFF", 1'b1, 1'b0);
    push_text("\\xa", 1'b1, 1'b0);      // lower-case hex digit
    push_text("\\x00", 1'b1, 1'b1);     // zero byte, sent into a drained pipe
    push_req(8'h01, 1'b1, 1'b0);        // raw control byte
    push_text("\\qZ", 1'b1, 1'b0);      // unknown escape, rest discarded
    push_text("\\", 1'b1, 1'b0);        // escape cut off at line end
    wait_idle();

    // random phases, each with its own settings; a phase may leave a line
    // open so the next one carries it on, maybe in the other direction
    random_start = queued_items;
    open_line = 1'b0;
    while (queued_items - random_start < RANDOM_ITEMS) begin
      wait_idle();
      dir = (phase < 4) ? phase[0] : 1'($urandom_range(1));
      case (phase)
        0:       maxl = 16'd1;
        1:       maxl = 16'hFFFF;
        3:       maxl = 16'($urandom_range(1, 8));
        default: maxl = $urandom_range(1) ? 16'($urandom_range(2, 24))
                                          : 16'($urandom_range(25, 65535));
      endcase
      write_reg(REG_DIRECTION, 16'(dir));
      write_reg(REG_MAX_LENGTH, maxl);
      calm = (phase == 3);
      phase_start = queued_items;
      while (queued_items - phase_start < PHASE_ITEMS) begin
        if (dir == DIR_DECODE) gen_escaped_line(1'b1);
        else gen_raw_line(1'b1);
      end
      open_line = (queued_items - random_start + PHASE_ITEMS < RANDOM_ITEMS) &&
                  ($urandom_range(99) < 30);
      if (open_line) begin
        if (dir == DIR_DECODE) gen_escaped_line(1'b0);
        else gen_raw_line(1'b0);
      end
      phase++;
    end
    wait_idle();
    calm = 1'b0;
    // room for any stray result after the last expected one
    repeat (10) @(posedge clk);

    $display("covered %0d input requests and %0d result requests in %0d random phases",
             items_accepted, results_seen, phase);
    $display("%0d lines closed with the error flag, %0d register writes",
             error_lines, cfg_writes);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("timeout: %0d results still pending", codec_out_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
